// ----- hdl/impq_pkg.sv -----
// Shared types and constants for the indexed min-priority queue.
// Used by impq_cell, impq_chain and indexed_min_priority_queue_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package impq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int KEY_BITS   = 32;
   localparam int ID_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_DUP    = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_REMOVE,
      CHAIN_SHIFT
   } chain_op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_INS,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  id;
   } entry_type;

   typedef struct packed {
      chain_op_type        op;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  id;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/impq_cell.sv -----
// One slot of the sorted queue chain: holds a single (key, id) entry.
// Depends on impq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module impq_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire impq_pkg::chain_ctrl_type ctrl,
   input  wire impq_pkg::entry_type      left_entry,
   input  wire                           left_after,
   input  wire impq_pkg::entry_type      right_entry,
   output impq_pkg::entry_type           own_entry,
   output logic                          own_after
);

   logic                                        valid_ff;
   logic                                        valid_in;
   logic [impq_pkg::KEY_BITS+impq_pkg::ID_BITS-1:0] data_ff;
   logic [impq_pkg::KEY_BITS+impq_pkg::ID_BITS-1:0] data_in;
   logic [impq_pkg::KEY_BITS+impq_pkg::ID_BITS-1:0] probe;
   logic                                        own_ge;

   // Empty slots order after everything; ties on key are broken by the id.
   assign probe     = {ctrl.key, ctrl.id};
   assign own_after = !valid_ff || (data_ff > probe);
   assign own_ge    = !valid_ff || (data_ff >= probe);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctrl.op)
         impq_pkg::CHAIN_INSERT: begin
            if (own_after) begin
               if (left_after) begin
                  valid_in = left_entry.valid;
                  data_in  = {left_entry.key, left_entry.id};
               end else begin
                  valid_in = 1'b1;
                  data_in  = probe;
               end
            end
         end
         impq_pkg::CHAIN_REMOVE: begin
            if (own_ge) begin
               valid_in = right_entry.valid;
               data_in  = {right_entry.key, right_entry.id};
            end
         end
         impq_pkg::CHAIN_SHIFT: begin
            valid_in = right_entry.valid;
            data_in  = {right_entry.key, right_entry.id};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign own_entry.valid = valid_ff;
   assign own_entry.key   = data_ff[impq_pkg::KEY_BITS+impq_pkg::ID_BITS-1:impq_pkg::ID_BITS];
   assign own_entry.id    = data_ff[impq_pkg::ID_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/impq_chain.sv -----
// Row of impq_cell slots kept sorted by (key, id); slot zero holds the minimum.
// Depends on impq_pkg and impq_cell.
`timescale 1ns / 1ps
`default_nettype none

module impq_chain (
   input  wire                           clock,
   input  wire                           reset,
   input  wire impq_pkg::chain_ctrl_type ctrl,
   output impq_pkg::entry_type           head_entry
);

   impq_pkg::entry_type entries [impq_pkg::CAPACITY];
   logic                after   [impq_pkg::CAPACITY];
   impq_pkg::entry_type empty_entry;

   assign empty_entry = '0;

   for (genvar i = 0; i < impq_pkg::CAPACITY; i++) begin : g_cell
      impq_pkg::entry_type left_entry;
      impq_pkg::entry_type right_entry;
      logic                left_after;

      if (i == 0) begin : g_first
         assign left_entry = empty_entry;
         assign left_after = 1'b0;
      end else begin : g_inner
         assign left_entry = entries[i-1];
         assign left_after = after[i-1];
      end

      if (i == impq_pkg::CAPACITY - 1) begin : g_last
         assign right_entry = empty_entry;
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      impq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_after  (left_after),
         .right_entry (right_entry),
         .own_entry   (entries[i]),
         .own_after   (after[i])
      );
   end

   assign head_entry = entries[0];

endmodule

`default_nettype wire

// ----- hdl/indexed_min_priority_queue_unit.sv -----
// Top level of the indexed min-priority queue: sequencer, id table and sorted cell chain.
// Depends on impq_pkg and impq_chain.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block clears all 1024 id table entries and holds busy high. Then busy stays
// high through the execute state for a pop or an unused command, through the lookup state for
// a push or an update of an id that is not queued, and through lookup then insert for an update
// of a queued id, as the id table read is registered and the chain removes, then inserts. Each
// command gets exactly one result, shown on the rsp_ ports for a single cycle with rsp_strobe
// high, in the first cycle in which busy is low again; the receiver cannot stall and must take
// it then. A new command may be started while that result is showing.
module indexed_min_priority_queue_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [1:0]                         req_cmd,
   input  wire  [impq_pkg::ID_BITS-1:0]       req_node_id,
   input  wire  [impq_pkg::KEY_BITS-1:0]      req_weight,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [impq_pkg::ID_BITS-1:0]       rsp_popped_id,
   output logic [impq_pkg::KEY_BITS-1:0]      rsp_popped_weight,
   output logic [impq_pkg::COUNT_BITS-1:0]    rsp_queued_count
);

   localparam logic [impq_pkg::ID_BITS-1:0] LAST_ADDR = impq_pkg::ID_BITS'(impq_pkg::CAPACITY - 1);

   impq_pkg::state_type                 state_ff, state_in;
   logic [impq_pkg::ID_BITS-1:0]        clr_ff, clr_in;
   logic [impq_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [1:0]                          cmd_ff;
   logic [impq_pkg::ID_BITS-1:0]        id_ff;
   logic [impq_pkg::KEY_BITS-1:0]       weight_ff;

   // Each table word holds the queued flag above the id's current key.
   logic [impq_pkg::KEY_BITS:0]         table_mem [impq_pkg::CAPACITY];
   logic [impq_pkg::KEY_BITS:0]         rd_data_ff;
   logic                                wr_en;
   logic [impq_pkg::ID_BITS-1:0]        wr_addr;
   logic [impq_pkg::KEY_BITS:0]         wr_data;

   impq_pkg::chain_ctrl_type            ctrl;
   impq_pkg::entry_type                 head_entry;

   logic                                accept;
   logic                                fire;
   logic [1:0]                          status_in;
   logic [impq_pkg::ID_BITS-1:0]        pid_in;
   logic [impq_pkg::KEY_BITS-1:0]       pweight_in;

   logic                                rsp_strobe_ff;
   logic [1:0]                          rsp_status_ff;
   logic [impq_pkg::ID_BITS-1:0]        rsp_id_ff;
   logic [impq_pkg::KEY_BITS-1:0]       rsp_weight_ff;
   logic [impq_pkg::COUNT_BITS-1:0]     rsp_count_ff;

   assign busy   = (state_ff != impq_pkg::S_IDLE);
   assign accept = start && !busy;

   impq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .head_entry (head_entry)
   );

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[req_node_id];
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      count_in   = count_ff;
      ctrl.op    = impq_pkg::CHAIN_HOLD;
      ctrl.key   = weight_ff;
      ctrl.id    = id_ff;
      wr_en      = 1'b0;
      wr_addr    = id_ff;
      wr_data    = {1'b1, weight_ff};
      fire       = 1'b0;
      status_in  = impq_pkg::ST_OK;
      pid_in     = '0;
      pweight_in = '0;

      unique case (state_ff)
         impq_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + impq_pkg::ID_BITS'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = impq_pkg::S_IDLE;
            end
         end
         impq_pkg::S_IDLE: begin
            if (start) begin
               if (req_cmd == impq_pkg::CMD_POP || req_cmd == impq_pkg::CMD_NOP) begin
                  state_in = impq_pkg::S_EXEC;
               end else begin
                  state_in = impq_pkg::S_LOOK;
               end
            end
         end
         impq_pkg::S_LOOK: begin
            state_in = impq_pkg::S_IDLE;
            fire     = 1'b1;
            if (cmd_ff == impq_pkg::CMD_PUSH) begin
               if (rd_data_ff[impq_pkg::KEY_BITS]) begin
                  status_in = impq_pkg::ST_DUP;
               end else begin
                  ctrl.op  = impq_pkg::CHAIN_INSERT;
                  wr_en    = 1'b1;
                  count_in = count_ff + impq_pkg::COUNT_BITS'(1);
               end
            end else if (!rd_data_ff[impq_pkg::KEY_BITS]) begin
               status_in = impq_pkg::ST_ABSENT;
            end else begin
               // Take the entry out under its old key; the new key goes in next cycle.
               fire     = 1'b0;
               ctrl.op  = impq_pkg::CHAIN_REMOVE;
               ctrl.key = rd_data_ff[impq_pkg::KEY_BITS-1:0];
               state_in = impq_pkg::S_INS;
            end
         end
         impq_pkg::S_INS: begin
            ctrl.op  = impq_pkg::CHAIN_INSERT;
            wr_en    = 1'b1;
            fire     = 1'b1;
            state_in = impq_pkg::S_IDLE;
         end
         impq_pkg::S_EXEC: begin
            fire     = 1'b1;
            state_in = impq_pkg::S_IDLE;
            if (cmd_ff == impq_pkg::CMD_POP) begin
               if (count_ff == '0) begin
                  status_in = impq_pkg::ST_EMPTY;
               end else begin
                  ctrl.op    = impq_pkg::CHAIN_SHIFT;
                  wr_en      = 1'b1;
                  wr_addr    = head_entry.id;
                  wr_data    = {1'b0, head_entry.key};
                  count_in   = count_ff - impq_pkg::COUNT_BITS'(1);
                  pid_in     = head_entry.id;
                  pweight_in = head_entry.key;
               end
            end
         end
         default: begin
            state_in = impq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= impq_pkg::S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         id_ff     <= req_node_id;
         weight_ff <= req_weight;
      end
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_id_ff     <= pid_in;
         rsp_weight_ff <= pweight_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_popped_id     = rsp_id_ff;
   assign rsp_popped_weight = rsp_weight_ff;
   assign rsp_queued_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != impq_pkg::S_INS) |-> (head_entry.valid == (count_ff != '0)))
      else $error("chain head validity disagrees with entry count");

   a_fail_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != impq_pkg::ST_OK) |->
         (rsp_popped_id == '0 && rsp_popped_weight == '0))
      else $error("refused command returned a nonzero popped entry");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == impq_pkg::S_CLEAR) |=> !rsp_strobe)
      else $error("result beat during table clearing");
`endif

endmodule

`default_nettype wire
